// ===== rtl/core/tlmna_pkg.sv =====
// tlmna_pkg: widths, codes and beat types shared by the neighbor address block
// no dependencies; the design files but tlmna_ram refer to it by scoped names
`default_nettype none

package tlmna_pkg;

   localparam int ROOT_DIM_MAX_DEF = 16;
   localparam int SUB_LEN_MAX_DEF  = 64;

   // field widths
   localparam int CELL_W    = 4;
   localparam int POINT_W   = 6;
   localparam int DIR_W     = 3;
   localparam int SIDE_W    = 7;
   localparam int DIM_W     = 5;
   localparam int ROOT_W    = 12;
   localparam int SUB_W     = 18;
   localparam int CSR_IDX_W = 2;

   // internal widths
   localparam int CRD_W  = DIM_W;              // cell coordinate after a step
   localparam int FLAT_W = 3 * DIM_W;          // flat root index before masking
   localparam int PROD_W = POINT_W + SIDE_W;   // point times side
   localparam int REM_W  = PROD_W + 1;
   localparam int QUO_W  = SIDE_W;
   localparam int T1_W   = 2 * SIDE_W + 1;
   localparam int T2_W   = T1_W + SIDE_W;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [DIR_W-1:0] DIR_POS_Z = 3'd0;
   localparam logic [DIR_W-1:0] DIR_NEG_Z = 3'd1;
   localparam logic [DIR_W-1:0] DIR_POS_Y = 3'd2;
   localparam logic [DIR_W-1:0] DIR_NEG_Y = 3'd3;
   localparam logic [DIR_W-1:0] DIR_POS_X = 3'd4;
   localparam logic [DIR_W-1:0] DIR_NEG_X = 3'd5;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROOT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROOT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROOT_DEPTH  = 2'd2;

   typedef struct packed {
      logic              kind;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [CELL_W-1:0] cell_z;
      logic [POINT_W-1:0] point_x;
      logic [POINT_W-1:0] point_y;
      logic [POINT_W-1:0] point_z;
      logic [DIR_W-1:0]  direction;
      logic [SIDE_W-1:0] side_length;
   } req_type;

   typedef struct packed {
      logic [ROOT_W-1:0] neighbor_root;
      logic [SUB_W-1:0]  neighbor_sub;
      logic              found;
   } rsp_type;

   typedef struct packed {
      logic [DIM_W-1:0] root_width;
      logic [DIM_W-1:0] root_height;
      logic [DIM_W-1:0] root_depth;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [FLAT_W-1:0] flat;
      logic [SIDE_W-1:0] wdata;
   } ram_req_type;

   // lookup after the table address is known
   typedef struct packed {
      logic [SIDE_W-1:0]       side;
      logic                    found;
      logic                    crossing;
      logic [1:0]              axis;
      logic                    up;
      logic [2:0][POINT_W-1:0] pnt;
      logic [ROOT_W-1:0]       root;
   } mid_type;

   // one stage of the rescale divider
   typedef struct packed {
      logic [2:0][REM_W-1:0] rem;
      logic [2:0][QUO_W-1:0] quo;
      logic [SIDE_W-1:0]     side;
      logic [SIDE_W-1:0]     n;
      logic                  found;
      logic                  crossing;
      logic [1:0]            axis;
      logic                  up;
      logic [ROOT_W-1:0]     root;
   } dstage_type;

endpackage

`default_nettype wire

// ===== rtl/core/tlmna_ram.sv =====
// tlmna_ram: generic single port synchronous ram with registered read
// no dependencies
`default_nettype none

module tlmna_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tlmna_addr.sv =====
// tlmna_addr: decodes a request beat, steps the cell or point, forms the flat root index
// and drives the table port; depends on tlmna_pkg
`default_nettype none

module tlmna_addr #(
   parameter int SUB_LEN_MAX = tlmna_pkg::SUB_LEN_MAX_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tlmna_pkg::cfg_type    cfg,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire tlmna_pkg::req_type    in_data,
   output tlmna_pkg::ram_req_type     ram_req,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output tlmna_pkg::mid_type         out_data
);

   localparam int SIDE_W  = tlmna_pkg::SIDE_W;
   localparam int POINT_W = tlmna_pkg::POINT_W;
   localparam int CRD_W   = tlmna_pkg::CRD_W;
   localparam int FLAT_W  = tlmna_pkg::FLAT_W;
   localparam logic [SIDE_W+1:0] SUB_LIM = (SIDE_W+2)'(SUB_LEN_MAX);

   typedef struct packed {
      logic                    is_write;
      logic                    wr_en;
      logic [SIDE_W-1:0]       wdata;
      logic [SIDE_W-1:0]       side;
      logic                    found;
      logic                    crossing;
      logic [1:0]              axis;
      logic                    up;
      logic [2:0][POINT_W-1:0] pnt;
      logic [CRD_W-1:0]        cx;
      logic [CRD_W-1:0]        cy;
      logic [2*CRD_W-1:0]      zh;
      logic [FLAT_W-1:0]       fp;
   } stg_type;

   logic                  v1_ff, v1_in, v2_ff, v2_in;
   stg_type               s1_ff, s1_in, s2_ff, s2_in, s1_new;
   logic                  ready1, ready2, s2_go;

   logic [2:0][CRD_W-1:0]   cur_cell, dims, cell_nb;
   logic [2:0][POINT_W-1:0] pnt, pnt_nb;
   logic [1:0]              axis;
   logic                    up, dir_ok, in_grid, side_ok, pnt_ok;
   logic                    internal, edge_hit;
   logic [POINT_W-1:0]      pnt_a;
   logic [CRD_W-1:0]        cell_a, dim_a;
   logic [SIDE_W-1:0]       side, side_m1;
   logic [2*CRD_W:0]        zy;
   logic [FLAT_W-1:0]       flat;

   // request decode and neighbor step
   always_comb begin
      side        = in_data.side_length;
      side_m1     = side - SIDE_W'(1);
      cur_cell[0] = CRD_W'(in_data.cell_x);
      cur_cell[1] = CRD_W'(in_data.cell_y);
      cur_cell[2] = CRD_W'(in_data.cell_z);
      pnt[0]  = in_data.point_x;
      pnt[1]  = in_data.point_y;
      pnt[2]  = in_data.point_z;
      dims[0] = cfg.root_width;
      dims[1] = cfg.root_height;
      dims[2] = cfg.root_depth;

      dir_ok = 1'b1;
      unique case (in_data.direction)
         tlmna_pkg::DIR_POS_Z: begin axis = tlmna_pkg::AXIS_Z; up = 1'b1; end
         tlmna_pkg::DIR_NEG_Z: begin axis = tlmna_pkg::AXIS_Z; up = 1'b0; end
         tlmna_pkg::DIR_POS_Y: begin axis = tlmna_pkg::AXIS_Y; up = 1'b1; end
         tlmna_pkg::DIR_NEG_Y: begin axis = tlmna_pkg::AXIS_Y; up = 1'b0; end
         tlmna_pkg::DIR_POS_X: begin axis = tlmna_pkg::AXIS_X; up = 1'b1; end
         tlmna_pkg::DIR_NEG_X: begin axis = tlmna_pkg::AXIS_X; up = 1'b0; end
         default: begin
            axis   = tlmna_pkg::AXIS_X;
            up     = 1'b0;
            dir_ok = 1'b0;
         end
      endcase

      in_grid = (cur_cell[0] < dims[0]) && (cur_cell[1] < dims[1]) &&
                (cur_cell[2] < dims[2]);
      side_ok = (side != '0) && ({2'b00, side} <= SUB_LIM);
      pnt_ok  = 1'b1;
      pnt_a   = '0;
      cell_a  = '0;
      dim_a   = '0;
      for (int i = 0; i < 3; i++) begin
         if ({1'b0, pnt[i]} >= side) begin
            pnt_ok = 1'b0;
         end
         if (axis == 2'(i)) begin
            pnt_a  = pnt[i];
            cell_a = cur_cell[i];
            dim_a  = dims[i];
         end
      end

      internal = up ? ({1'b0, pnt_a} < side_m1) : (pnt_a != '0);
      edge_hit = up ? ((cell_a + CRD_W'(1)) >= dim_a) : (cell_a == '0);

      cell_nb = cur_cell;
      pnt_nb  = pnt;
      if (in_data.kind == tlmna_pkg::KIND_LOOKUP) begin
         for (int i = 0; i < 3; i++) begin
            if (axis == 2'(i)) begin
               if (internal) begin
                  pnt_nb[i] = up ? pnt_a + POINT_W'(1) : pnt_a - POINT_W'(1);
               end else begin
                  cell_nb[i] = up ? cell_a + CRD_W'(1) : cell_a - CRD_W'(1);
               end
            end
         end
      end

      s1_new.is_write = (in_data.kind == tlmna_pkg::KIND_WRITE);
      s1_new.wr_en    = in_grid;
      s1_new.wdata    = ({2'b00, side} <= SUB_LIM) ? side : '0;
      s1_new.side     = side;
      s1_new.found    = in_grid && side_ok && dir_ok && pnt_ok && (internal || !edge_hit);
      s1_new.crossing = !internal;
      s1_new.axis     = axis;
      s1_new.up       = up;
      s1_new.pnt      = pnt_nb;
      s1_new.cx       = cell_nb[0];
      s1_new.cy       = cell_nb[1];
      s1_new.zh       = (2*CRD_W)'(cell_nb[2]) * (2*CRD_W)'(dims[1]);
      s1_new.fp       = '0;
   end

   // pipeline control; a write beat retires at the table port
   always_comb begin
      s2_go    = v2_ff && (s2_ff.is_write || out_ready);
      ready2   = !v2_ff || s2_go;
      ready1   = !v1_ff || ready2;
      in_ready = ready1;

      v1_in = ready1 ? in_valid : v1_ff;
      v2_in = ready2 ? v1_ff : v2_ff;
      s1_in = (ready1 && in_valid) ? s1_new : s1_ff;

      zy       = (2*CRD_W+1)'(s1_ff.zh) + (2*CRD_W+1)'(s1_ff.cy);
      s2_in    = s1_ff;
      s2_in.fp = FLAT_W'(FLAT_W'(zy) * FLAT_W'(cfg.root_width));
      if (!(ready2 && v1_ff)) begin
         s2_in = s2_ff;
      end

      flat = s2_ff.fp + FLAT_W'(s2_ff.cx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

   always_comb begin
      ram_req.we    = s2_go && s2_ff.is_write && s2_ff.wr_en;
      ram_req.re    = s2_go && !s2_ff.is_write && s2_ff.found && s2_ff.crossing;
      ram_req.flat  = flat;
      ram_req.wdata = s2_ff.wdata;

      out_valid         = v2_ff && !s2_ff.is_write;
      out_data.side     = s2_ff.side;
      out_data.found    = s2_ff.found;
      out_data.crossing = s2_ff.crossing;
      out_data.axis     = s2_ff.axis;
      out_data.up       = s2_ff.up;
      out_data.pnt      = s2_ff.pnt;
      out_data.root     = flat[tlmna_pkg::ROOT_W-1:0];
   end

endmodule

`default_nettype wire

// ===== rtl/core/tlmna_rescale.sv =====
// tlmna_rescale: picks the neighbor side from the table, forms point times side and
// divides by the current side in a one-bit-per-stage pipeline; depends on tlmna_pkg
`default_nettype none

module tlmna_rescale #(
   parameter int SUB_LEN_MAX = tlmna_pkg::SUB_LEN_MAX_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire tlmna_pkg::mid_type            in_data,
   input  wire logic [tlmna_pkg::SIDE_W-1:0]  ram_rdata,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output tlmna_pkg::dstage_type              out_data
);

   localparam int SIDE_W = tlmna_pkg::SIDE_W;
   localparam int REM_W  = tlmna_pkg::REM_W;
   localparam int QUO_W  = tlmna_pkg::QUO_W;
   localparam logic [SIDE_W+1:0] SUB_LIM = (SIDE_W+2)'(SUB_LEN_MAX);

   logic                  v3_ff, v3_in, ready3;
   tlmna_pkg::mid_type    m3_ff, m3_in;
   tlmna_pkg::dstage_type d0;
   logic [SIDE_W-1:0]     n;

   logic                  dv_ff [QUO_W+1];
   logic                  dv_in [QUO_W+1];
   logic                  rdy_d [QUO_W+1];
   tlmna_pkg::dstage_type dp_ff [QUO_W+1];
   tlmna_pkg::dstage_type dp_in [QUO_W+1];
   tlmna_pkg::dstage_type step  [QUO_W+1];
   logic [REM_W-1:0]      dsor;

   always_comb begin
      rdy_d[QUO_W] = !dv_ff[QUO_W] || out_ready;
      for (int k = QUO_W - 1; k >= 0; k--) begin
         rdy_d[k] = !dv_ff[k] || rdy_d[k+1];
      end
      ready3   = !v3_ff || rdy_d[0];
      in_ready = ready3;

      v3_in = ready3 ? in_valid : v3_ff;
      m3_in = (ready3 && in_valid) ? in_data : m3_ff;
   end

   // table data is held in the ram read register while this stage waits
   always_comb begin
      n           = m3_ff.crossing ? ram_rdata : m3_ff.side;
      d0.quo      = '0;
      d0.side     = m3_ff.side;
      d0.n        = n;
      d0.found    = m3_ff.found &&
                    !(m3_ff.crossing && ((n == '0) || ({2'b00, n} > SUB_LIM)));
      d0.crossing = m3_ff.crossing;
      d0.axis     = m3_ff.axis;
      d0.up       = m3_ff.up;
      d0.root     = m3_ff.root;
      for (int i = 0; i < 3; i++) begin
         d0.rem[i] = REM_W'(REM_W'(m3_ff.pnt[i]) * REM_W'(n));
      end
   end

   // restoring divide, quotient bits from the top down
   always_comb begin
      dsor    = '0;
      step[0] = d0;
      for (int k = 1; k <= QUO_W; k++) begin
         step[k] = dp_ff[k-1];
         dsor    = REM_W'(dp_ff[k-1].side) << (QUO_W - k);
         for (int i = 0; i < 3; i++) begin
            if (dp_ff[k-1].rem[i] >= dsor) begin
               step[k].rem[i]            = dp_ff[k-1].rem[i] - dsor;
               step[k].quo[i][QUO_W - k] = 1'b1;
            end
         end
      end

      dv_in[0] = rdy_d[0] ? v3_ff : dv_ff[0];
      dp_in[0] = (rdy_d[0] && v3_ff) ? step[0] : dp_ff[0];
      for (int k = 1; k <= QUO_W; k++) begin
         dv_in[k] = rdy_d[k] ? dv_ff[k-1] : dv_ff[k];
         dp_in[k] = (rdy_d[k] && dv_ff[k-1]) ? step[k] : dp_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         for (int k = 0; k <= QUO_W; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else begin
         v3_ff <= v3_in;
         for (int k = 0; k <= QUO_W; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      m3_ff <= m3_in;
      for (int k = 0; k <= QUO_W; k++) begin
         dp_ff[k] <= dp_in[k];
      end
   end

   assign out_valid = dv_ff[QUO_W];
   assign out_data  = dp_ff[QUO_W];

endmodule

`default_nettype wire

// ===== rtl/core/tlmna_subidx.sv =====
// tlmna_subidx: sets the crossed coordinate, forms the flat sub index and holds the
// response register; depends on tlmna_pkg
`default_nettype none

module tlmna_subidx (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire tlmna_pkg::dstage_type  in_data,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output tlmna_pkg::rsp_type          out_data
);

   localparam int SIDE_W = tlmna_pkg::SIDE_W;
   localparam int QUO_W  = tlmna_pkg::QUO_W;
   localparam int T1_W   = tlmna_pkg::T1_W;
   localparam int T2_W   = tlmna_pkg::T2_W;

   typedef struct packed {
      logic [T1_W-1:0]             t1;
      logic [QUO_W-1:0]            x;
      logic [SIDE_W-1:0]           n;
      logic [tlmna_pkg::ROOT_W-1:0] root;
      logic                        found;
   } sb_type;

   logic                     vb_ff, vb_in, vo_ff, vo_in;
   logic                     rdy_b, rdy_o;
   sb_type                   sb_ff, sb_in, sb_new;
   tlmna_pkg::rsp_type       rsp_ff, rsp_in, rsp_new;
   logic [2:0][QUO_W-1:0]    crd;
   logic [T2_W-1:0]          t2;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         crd[i] = in_data.quo[i];
         if (in_data.crossing && (in_data.axis == 2'(i))) begin
            crd[i] = in_data.up ? '0 : in_data.n - SIDE_W'(1);
         end
      end
      sb_new.t1    = T1_W'(T1_W'(crd[2]) * T1_W'(in_data.n)) + T1_W'(crd[1]);
      sb_new.x     = crd[0];
      sb_new.n     = in_data.n;
      sb_new.root  = in_data.root;
      sb_new.found = in_data.found;

      t2 = T2_W'(T2_W'(sb_ff.t1) * T2_W'(sb_ff.n)) + T2_W'(sb_ff.x);
      rsp_new.found         = sb_ff.found;
      rsp_new.neighbor_root = sb_ff.found ? sb_ff.root : '0;
      rsp_new.neighbor_sub  = sb_ff.found ? t2[tlmna_pkg::SUB_W-1:0] : '0;

      rdy_o    = !vo_ff || out_ready;
      rdy_b    = !vb_ff || rdy_o;
      in_ready = rdy_b;

      vb_in  = rdy_b ? in_valid : vb_ff;
      vo_in  = rdy_o ? vb_ff : vo_ff;
      sb_in  = (rdy_b && in_valid) ? sb_new : sb_ff;
      rsp_in = (rdy_o && vb_ff) ? rsp_new : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         vb_ff <= vb_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      sb_ff  <= sb_in;
      rsp_ff <= rsp_in;
   end

   assign out_valid = vo_ff;
   assign out_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/two_level_mesh_neighbor_address.sv =====
// two_level_mesh_neighbor_address: side table of a two-level mesh and neighbor lookup
// a lookup beat passes the address, rescale and sub index stages to rsp; write beats give no rsp
// throughput: one beat per cycle unless stalled; a single table port serves reads and writes
// reset: synchronous; registers go to 16 (clamped), then all ROOT_DIM_MAX**3 table entries
// (4096 by default) are swept to zero while req_stall is held; csr writes still land
`default_nettype none

module two_level_mesh_neighbor_address #(
   parameter int ROOT_DIM_MAX = tlmna_pkg::ROOT_DIM_MAX_DEF,
   parameter int SUB_LEN_MAX  = tlmna_pkg::SUB_LEN_MAX_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire tlmna_pkg::req_type               req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output tlmna_pkg::rsp_type                    rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [tlmna_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [tlmna_pkg::DIM_W-1:0]      csr_wdata
);

   localparam int DIM_W  = tlmna_pkg::DIM_W;
   localparam int SIDE_W = tlmna_pkg::SIDE_W;
   localparam int FLAT_W = tlmna_pkg::FLAT_W;
   localparam int DEPTH  = ROOT_DIM_MAX * ROOT_DIM_MAX * ROOT_DIM_MAX;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if ({2'b00, v} > (DIM_W+2)'(ROOT_DIM_MAX)) begin
         r = DIM_W'(ROOT_DIM_MAX);
      end else begin
         r = v;
      end
      return r;
   endfunction

   tlmna_pkg::cfg_type     cfg_ff, cfg_in;
   logic                   clear_ff, clear_in;
   logic [ADDR_W-1:0]      clr_addr_ff, clr_addr_in;

   tlmna_pkg::ram_req_type ram_req;
   tlmna_pkg::mid_type     mid_data;
   tlmna_pkg::dstage_type  div_data;
   logic                   front_ready, mid_valid, mid_ready, div_valid, div_ready;
   logic                   ram_we, ram_re;
   logic [ADDR_W-1:0]      ram_addr;
   logic [SIDE_W-1:0]      ram_wdata, ram_rdata;
   logic [FLAT_W+ADDR_W-1:0] flat_ext;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            tlmna_pkg::REG_ROOT_WIDTH:  cfg_in.root_width  = clamp_dim(csr_wdata);
            tlmna_pkg::REG_ROOT_HEIGHT: cfg_in.root_height = clamp_dim(csr_wdata);
            tlmna_pkg::REG_ROOT_DEPTH:  cfg_in.root_depth  = clamp_dim(csr_wdata);
            default: cfg_in = cfg_ff;
         endcase
      end

      // clearing sweep, one entry a cycle
      clear_in    = clear_ff && (clr_addr_ff != ADDR_W'(DEPTH - 1));
      clr_addr_in = clear_ff ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.root_width  <= clamp_dim(DIM_W'(16));
         cfg_ff.root_height <= clamp_dim(DIM_W'(16));
         cfg_ff.root_depth  <= clamp_dim(DIM_W'(16));
         clear_ff           <= 1'b1;
         clr_addr_ff        <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign req_stall = clear_ff || !front_ready;

   tlmna_addr #(
      .SUB_LEN_MAX (SUB_LEN_MAX)
   ) u_addr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid && !clear_ff),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .ram_req   (ram_req),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   always_comb begin
      flat_ext  = {{ADDR_W{1'b0}}, ram_req.flat};
      ram_we    = clear_ff || ram_req.we;
      ram_re    = !clear_ff && ram_req.re;
      ram_addr  = clear_ff ? clr_addr_ff : flat_ext[ADDR_W-1:0];
      ram_wdata = clear_ff ? '0 : ram_req.wdata;
   end

   tlmna_ram #(
      .WIDTH (SIDE_W),
      .DEPTH (DEPTH)
   ) u_side_table (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   tlmna_rescale #(
      .SUB_LEN_MAX (SUB_LEN_MAX)
   ) u_rescale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .ram_rdata (ram_rdata),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   tlmna_subidx u_subidx (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   // no lookup or write reaches the table during the sweep
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> (!ram_req.we && !ram_req.re))
      else $error("table access during clearing sweep");

   // one port: a beat either reads or writes
   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.we && ram_req.re))
      else $error("table read and write in the same cycle");

   // pipeline is empty when the sweep ends
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> (!rsp_valid && !mid_valid && !div_valid))
      else $error("beat in flight at end of clearing sweep");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for two_level_mesh_neighbor_address, side table writes and lookups
// depends on tlmna_pkg and the block itself; predicts every rsp beat and checks it in order
`timescale 1ns / 100ps

module tb_top;
   import tlmna_pkg::*;

   localparam int unsigned STALL_LIMIT  = 20000;  // covers the table sweep after reset
   localparam int unsigned DRAIN_CYCLES = 24;     // longer than a lookup takes to pass the pipeline
   localparam int unsigned HOLD_PHASE   = 2;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned MIXED_BEATS  = 30;
   localparam int unsigned WINDOW_SPAN  = 3;
   localparam int unsigned GAP_CAP      = 40;

   localparam logic [DIR_W-1:0]     DIR_SPARE_A = 3'd6;
   localparam logic [DIR_W-1:0]     DIR_SPARE_B = 3'd7;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED  = 2'd3;

   class neighbor_scoreboard;
      logic [SIDE_W-1:0] side_table [ROOT_DIM_MAX_DEF*ROOT_DIM_MAX_DEF*ROOT_DIM_MAX_DEF];
      int unsigned       dims [3];
      rsp_type           expected_neighbors [$];
      int unsigned       failures;

      function new();
         foreach (side_table[i]) side_table[i] = '0;
         dims = '{ROOT_DIM_MAX_DEF, ROOT_DIM_MAX_DEF, ROOT_DIM_MAX_DEF};
         failures = 0;
      endfunction

      function void set_dim(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
         int unsigned v;
         v = value;
         if (v < 1) v = 1;
         if (v > ROOT_DIM_MAX_DEF) v = ROOT_DIM_MAX_DEF;
         case (idx)
            REG_ROOT_WIDTH:  dims[0] = v;
            REG_ROOT_HEIGHT: dims[1] = v;
            REG_ROOT_DEPTH:  dims[2] = v;
            default: ;
         endcase
      endfunction

      static function int unsigned axis_of(logic [DIR_W-1:0] dir);
         case (dir)
            DIR_POS_Z, DIR_NEG_Z: return AXIS_Z;
            DIR_POS_Y, DIR_NEG_Y: return AXIS_Y;
            default:              return AXIS_X;
         endcase
      endfunction

      static function bit is_up(logic [DIR_W-1:0] dir);
         return dir == DIR_POS_Z || dir == DIR_POS_Y || dir == DIR_POS_X;
      endfunction

      function int unsigned flat_of(int unsigned c [3]);
         return (c[2] * dims[1] + c[1]) * dims[0] + c[0];
      endfunction

      // applies a table write or works out the neighbor of a lookup; 1 when a rsp beat follows
      function bit resolve(input req_type r, output rsp_type nb);
         int unsigned c [3];
         int unsigned p [3];
         int unsigned s, n, ax;
         bit up;
         nb = '0;
         c = '{r.cell_x, r.cell_y, r.cell_z};
         p = '{r.point_x, r.point_y, r.point_z};
         if (c[0] >= dims[0] || c[1] >= dims[1] || c[2] >= dims[2])
            return r.kind == KIND_LOOKUP;
         if (r.kind == KIND_WRITE) begin
            side_table[flat_of(c)] = (r.side_length <= SUB_LEN_MAX_DEF) ? r.side_length : '0;
            return 0;
         end
         s = r.side_length;
         if (s == 0 || s > SUB_LEN_MAX_DEF || r.direction > DIR_NEG_X) return 1;
         if (p[0] >= s || p[1] >= s || p[2] >= s) return 1;
         ax = axis_of(r.direction);
         up = is_up(r.direction);
         n = s;
         if (up && p[ax] < s - 1) begin
            p[ax] = p[ax] + 1;
         end else if (!up && p[ax] > 0) begin
            p[ax] = p[ax] - 1;
         end else begin
            // step into the adjacent root cell and rescale the in-plane point
            if (up) begin
               if (c[ax] + 1 >= dims[ax]) return 1;
               c[ax] = c[ax] + 1;
            end else begin
               if (c[ax] == 0) return 1;
               c[ax] = c[ax] - 1;
            end
            n = side_table[flat_of(c)];
            if (n == 0 || n > SUB_LEN_MAX_DEF) return 1;
            for (int i = 0; i < 3; i++)
               if (i != ax) p[i] = (p[i] * n) / s;
            p[ax] = up ? 0 : n - 1;
         end
         nb.neighbor_root = ROOT_W'(flat_of(c));
         nb.neighbor_sub  = SUB_W'((p[2] * n + p[1]) * n + p[0]);
         nb.found         = 1'b1;
         return 1;
      endfunction

      function void note_request(req_type r);
         rsp_type nb;
         if (resolve(r, nb)) expected_neighbors.push_back(nb);
      endfunction

      function void flag(string what, rsp_type want, rsp_type got);
         failures++;
         if (failures <= 10)
            $display("%s: expected root %0d sub %0d found %0b, got root %0d sub %0d found %0b",
                     what, want.neighbor_root, want.neighbor_sub, want.found,
                     got.neighbor_root, got.neighbor_sub, got.found);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_neighbors.size() == 0) begin
            flag("rsp beat with nothing pending", '0, got);
            return;
         end
         want = expected_neighbors.pop_front();
         if (got.neighbor_root !== want.neighbor_root || got.neighbor_sub !== want.neighbor_sub ||
             got.found !== want.found)
            flag("rsp mismatch", want, got);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DIM_W-1:0]     csr_wdata;

   neighbor_scoreboard sb;
   int unsigned        send_idle_pct;
   int unsigned        stall_pct;
   int unsigned        phase_no;
   int unsigned        hold_left;
   bit                 hold_done;
   int unsigned        quiet_cycles;

   two_level_mesh_neighbor_address u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic req_type make_req(input logic kind, input int unsigned cx, cy, cz,
                                        input int unsigned px, py, pz,
                                        input logic [DIR_W-1:0] dir, input int unsigned side);
      req_type r;
      r.kind        = kind;
      r.cell_x      = CELL_W'(cx);
      r.cell_y      = CELL_W'(cy);
      r.cell_z      = CELL_W'(cz);
      r.point_x     = POINT_W'(px);
      r.point_y     = POINT_W'(py);
      r.point_z     = POINT_W'(pz);
      r.direction   = dir;
      r.side_length = SIDE_W'(side);
      return r;
   endfunction

   function automatic int unsigned pick_side();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(8, 1);
      if (roll < 90) return $urandom_range(SUB_LEN_MAX_DEF, 9);
      if (roll < 95) return 0;
      return $urandom_range(127, SUB_LEN_MAX_DEF + 1);
   endfunction

   task automatic send_beat(input req_type r);
      int unsigned gap;
      gap = 0;
      while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   // sender pauses until every pending lookup has come back, then lets the pipe empty
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_neighbors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dims(input logic [DIM_W-1:0] w, h, d);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [DIM_W-1:0]     vals [4];
      idx  = '{REG_ROOT_WIDTH, REG_ROOT_HEIGHT, REG_ROOT_DEPTH, REG_UNUSED};
      vals = '{w, h, d, DIM_W'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         sb.set_dim(idx[i], vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned p);
      case (p % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 73; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 73; end
         default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
   endtask

   task automatic send_directed();
      send_beat(make_req(KIND_WRITE, 0, 0, 0, 0, 0, 0, DIR_POS_Z, 4));
      send_beat(make_req(KIND_WRITE, 1, 0, 0, 0, 0, 0, DIR_POS_Z, 8));
      send_beat(make_req(KIND_WRITE, 0, 1, 0, 0, 0, 0, DIR_POS_Z, 64));
      send_beat(make_req(KIND_WRITE, 0, 0, 1, 0, 0, 0, DIR_POS_Z, 1));
      send_beat(make_req(KIND_WRITE, 15, 15, 15, 63, 63, 63, DIR_SPARE_B, 64));
      // oversized side lands as an empty cell
      send_beat(make_req(KIND_WRITE, 14, 15, 15, 0, 0, 0, DIR_POS_Z, 127));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 1, 1, 1, DIR_POS_X, 4));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 3, 2, 1, DIR_POS_X, 4));
      send_beat(make_req(KIND_LOOKUP, 1, 0, 0, 0, 7, 5, DIR_NEG_X, 8));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 1, 3, 2, DIR_POS_Y, 4));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 2, 1, 3, DIR_POS_Z, 4));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 0, 1, 1, DIR_NEG_X, 4));
      send_beat(make_req(KIND_LOOKUP, 15, 15, 15, 63, 0, 0, DIR_POS_X, 64));
      send_beat(make_req(KIND_LOOKUP, 15, 15, 15, 0, 5, 9, DIR_NEG_X, 64));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, DIR_POS_Z, 0));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, DIR_POS_Z, 65));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 1, 4, 1, DIR_POS_X, 4));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 1, 1, 1, DIR_SPARE_A, 4));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 0, 1, 1, 1, DIR_SPARE_B, 4));
      send_beat(make_req(KIND_LOOKUP, 15, 15, 15, 63, 63, 63, DIR_NEG_Z, 64));
      // current cell is empty in the table but the given side still counts
      send_beat(make_req(KIND_LOOKUP, 5, 5, 5, 1, 2, 0, DIR_NEG_Y, 3));
      send_beat(make_req(KIND_LOOKUP, 0, 0, 1, 0, 0, 0, DIR_NEG_Z, 1));
      send_beat(make_req(KIND_WRITE, 0, 0, 0, 0, 0, 0, DIR_POS_Z, 0));
      send_beat(make_req(KIND_LOOKUP, 1, 0, 0, 0, 0, 0, DIR_NEG_X, 8));
   endtask

   task automatic random_traffic();
      int unsigned span [3];
      int unsigned lo [3];
      int unsigned c [3];
      int unsigned p [3];
      int unsigned s, ax, roll;
      logic [DIR_W-1:0] dir;
      logic [63:0] raw;
      req_type r;
      for (int a = 0; a < 3; a++) begin
         span[a] = (sb.dims[a] < WINDOW_SPAN) ? sb.dims[a] : WINDOW_SPAN;
         lo[a]   = $urandom_range(sb.dims[a] - span[a]);
      end
      // load a small window of root cells so crossings mostly land on filled cells
      for (int z = 0; z < span[2]; z++)
         for (int y = 0; y < span[1]; y++)
            for (int x = 0; x < span[0]; x++)
               send_beat(make_req(KIND_WRITE, lo[0] + x, lo[1] + y, lo[2] + z, $urandom,
                                  $urandom, $urandom, DIR_W'($urandom), pick_side()));
      repeat (MIXED_BEATS) begin
         roll = $urandom_range(99);
         for (int a = 0; a < 3; a++) c[a] = lo[a] + $urandom_range(span[a] - 1);
         if (roll < 10) begin
            raw = {$urandom, $urandom};
            r = req_type'(raw[$bits(req_type)-1:0]);
         end else if (roll < 20) begin
            r = make_req(KIND_WRITE, c[0], c[1], c[2], $urandom, $urandom, $urandom,
                         DIR_W'($urandom), pick_side());
         end else begin
            s = sb.side_table[sb.flat_of(c)];
            if (s == 0 || s > SUB_LEN_MAX_DEF || $urandom_range(99) < 20) s = pick_side();
            dir = DIR_W'($urandom_range(DIR_NEG_X));
            ax = neighbor_scoreboard::axis_of(dir);
            for (int a = 0; a < 3; a++) p[a] = (s > 0) ? $urandom_range(s - 1) : 0;
            if (s > 0 && $urandom_range(99) < 60)
               p[ax] = neighbor_scoreboard::is_up(dir) ? s - 1 : 0;
            r = make_req(KIND_LOOKUP, c[0], c[1], c[2], p[0], p[1], p[2], dir, s);
         end
         send_beat(r);
      end
   endtask

   // rsp side: check accepted beats, stall at random, one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (phase_no == HOLD_PHASE && !hold_done && rsp_valid) begin
         rsp_stall <= 1'b1;
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("two_level_mesh_neighbor_address regression: fail");
            $finish;
         end
      end
   end

   initial begin
      logic [DIM_W-1:0] cfg_w [7];
      logic [DIM_W-1:0] cfg_h [7];
      logic [DIM_W-1:0] cfg_d [7];
      // zero acts as one, anything above sixteen as sixteen
      cfg_w = '{16, 4, 0, 31, 2, 16, 3};
      cfg_h = '{16, 4, 0, 17, 3, 1, 16};
      cfg_d = '{16, 4, 0, 16, 5, 2, 3};
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      hold_left = 0;
      hold_done = 1'b0;
      quiet_cycles = 0;
      phase_no = 0;
      set_idling(0);
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_directed();
      random_traffic();
      for (int ph = 1; ph < 7; ph++) begin
         drain();
         write_dims(cfg_w[ph], cfg_h[ph], cfg_d[ph]);
         phase_no = ph;
         set_idling(ph);
         if (ph == 1) begin
            // cells outside the root grid
            send_beat(make_req(KIND_WRITE, 5, 0, 0, 0, 0, 0, DIR_POS_Z, 9));
            send_beat(make_req(KIND_WRITE, 0, 0, 15, 0, 0, 0, DIR_POS_Z, 9));
            send_beat(make_req(KIND_LOOKUP, 4, 0, 0, 1, 1, 1, DIR_POS_X, 4));
            send_beat(make_req(KIND_LOOKUP, 0, 3, 15, 1, 1, 1, DIR_NEG_Z, 4));
         end
         random_traffic();
      end
      drain();
      sb.failures += sb.expected_neighbors.size();
      if (sb.failures == 0) begin
         $display("two_level_mesh_neighbor_address regression: pass");
      end else begin
         $display("two_level_mesh_neighbor_address regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tlmna_pkg.sv
rtl/core/tlmna_ram.sv
rtl/core/tlmna_addr.sv
rtl/core/tlmna_rescale.sv
rtl/core/tlmna_subidx.sv
rtl/core/two_level_mesh_neighbor_address.sv
test/tb_top.sv
